@@ rtl/mexp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation package
// Widths, configuration register indexes and the request/response types
// of the shared modular multiplier.
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int PROD_WIDTH    = 2 * DATA_WIDTH;
  localparam int STEP_WIDTH    = $clog2(PROD_WIDTH);
  localparam int CFG_IDX_WIDTH = 2;

  typedef logic [DATA_WIDTH-1:0]    word_t;
  typedef logic [CFG_IDX_WIDTH-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_EXPONENT = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_MODULUS  = cfg_idx_t'(1);

  typedef struct packed {
    logic  start;
    word_t a;
    word_t b;
  } mm_req_t;

  typedef struct packed {
    logic  done;
    word_t result;
  } mm_rsp_t;

endpackage

@@ rtl/mexp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation channels
// Valid/ready channels for the base value and the result value.
// ----------------------------------------------------------------------------
interface mexp_in_if;
  logic             valid;
  logic             ready;
  mexp_pkg::word_t  base_value;

  modport source (output valid, output base_value, input ready);
  modport sink   (input valid, input base_value, output ready);
endinterface

interface mexp_out_if;
  logic             valid;
  logic             ready;
  mexp_pkg::word_t  result_value;

  modport source (output valid, output result_value, input ready);
  modport sink   (input valid, input result_value, output ready);
endinterface

@@ rtl/mexp_mulmod.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular multiplier
// A registered multiply, then a restoring remainder one product bit per
// cycle. A zero modulus wraps the product to the data width instead.
// ----------------------------------------------------------------------------
module mexp_mulmod (
  input  logic              clk,
  input  logic              rst_n,
  input  mexp_pkg::word_t   modulus,
  input  mexp_pkg::mm_req_t req,
  output mexp_pkg::mm_rsp_t rsp
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    MM_IDLE = 3'b001,
    MM_DIV  = 3'b010,
    MM_WRAP = 3'b100
  } mm_state_t;

  localparam logic [STEP_WIDTH-1:0] LAST_STEP = STEP_WIDTH'(PROD_WIDTH - 1);

  mm_state_t               state_r;
  logic [PROD_WIDTH-1:0]   prod_r;
  word_t                   rem_r;
  logic [STEP_WIDTH-1:0]   step_r;
  logic                    done_r;
  word_t                   result_r;

  logic [DATA_WIDTH:0]     rem_shift;
  logic [DATA_WIDTH:0]     mod_ext;
  logic [DATA_WIDTH:0]     rem_sub;
  word_t                   rem_nxt;

  assign rem_shift = {rem_r, prod_r[PROD_WIDTH-1]};
  assign mod_ext   = {1'b0, modulus};
  assign rem_sub   = rem_shift - mod_ext;
  assign rem_nxt   = (rem_shift >= mod_ext) ? rem_sub[DATA_WIDTH-1:0]
                                             : rem_shift[DATA_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= MM_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (state_r)
        MM_IDLE: begin
          if (req.start) begin
            state_r <= (modulus == '0) ? MM_WRAP : MM_DIV;
          end
        end
        MM_DIV: begin
          if (step_r == LAST_STEP) begin
            state_r <= MM_IDLE;
            done_r  <= 1'b1;
          end
        end
        MM_WRAP: begin
          state_r <= MM_IDLE;
          done_r  <= 1'b1;
        end
        default: state_r <= MM_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      MM_IDLE: begin
        prod_r <= PROD_WIDTH'(req.a) * PROD_WIDTH'(req.b);
        rem_r  <= '0;
        step_r <= '0;
      end
      MM_DIV: begin
        prod_r <= {prod_r[PROD_WIDTH-2:0], 1'b0};
        rem_r  <= rem_nxt;
        step_r <= step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          result_r <= rem_nxt;
        end
      end
      MM_WRAP: begin
        result_r <= prod_r[DATA_WIDTH-1:0];
      end
      default: begin
        step_r <= '0;
      end
    endcase
  end

  assign rsp.done   = done_r;
  assign rsp.result = result_r;

endmodule

@@ rtl/modular_exponentiation_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation unit
// Returns base_value ^ exponent mod modulus by square-and-multiply over a
// shared modular multiplier.
//
//   channel   dir   payload              handshake
//   in_chan   in    base_value [15:0]    valid / ready
//   out_chan  out   result_value [15:0]  valid / ready
//   cfg_*     in    exponent, modulus    cfg_we, no wait
//
// Each modular product is a multiply and then 32 remainder steps, and each
// exponent bit passes through S_STEP; a zero modulus wraps a product instead
// of the remainder steps. Exponent 0xFFFF is the worst case. A zero exponent
// skips the multiplier and goes to S_DONE with a result of 1.
// in_chan.ready is high only while idle; a waiting result does not block the
// next item, which holds in S_DONE. Synchronous reset: exponent 0, modulus 2.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  mexp_in_if.sink              in_chan,
  mexp_out_if.source           out_chan,
  input  logic                 cfg_we,
  input  mexp_pkg::cfg_idx_t   cfg_index,
  input  mexp_pkg::word_t      cfg_wdata
);
  import mexp_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_BASE = 6'b000010,
    S_STEP = 6'b000100,
    S_MUL  = 6'b001000,
    S_SQR  = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t  state_r, state_nxt;
  word_t   exp_r, mod_r;
  word_t   e_r, e_nxt;
  word_t   acc_r, acc_nxt;
  word_t   sq_r, sq_nxt;
  logic    out_valid_r, out_valid_nxt;
  word_t   out_result_r, out_result_nxt;
  word_t   e_shift;

  mm_req_t mm_req;
  mm_rsp_t mm_rsp;

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (mod_r),
    .req     (mm_req),
    .rsp     (mm_rsp)
  );

  assign e_shift = e_r >> 1;

  always_comb begin
    state_nxt      = state_r;
    e_nxt          = e_r;
    acc_nxt        = acc_r;
    sq_nxt         = sq_r;
    out_valid_nxt  = out_valid_r && !out_chan.ready;
    out_result_nxt = out_result_r;
    mm_req.start   = 1'b0;
    mm_req.a       = acc_r;
    mm_req.b       = sq_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          e_nxt = exp_r;
          if (exp_r == '0) begin
            acc_nxt   = word_t'(1);
            state_nxt = S_DONE;
          end else begin
            mm_req.start = 1'b1;
            mm_req.a     = in_chan.base_value;
            mm_req.b     = word_t'(1);
            state_nxt    = S_BASE;
          end
        end
      end
      S_BASE: begin
        if (mm_rsp.done) begin
          sq_nxt    = mm_rsp.result;
          acc_nxt   = (mod_r == word_t'(1)) ? '0 : word_t'(1);
          state_nxt = S_STEP;
        end
      end
      S_STEP: begin
        mm_req.start = 1'b1;
        if (e_r[0]) begin
          state_nxt = S_MUL;
        end else begin
          e_nxt     = e_shift;
          mm_req.a  = sq_r;
          state_nxt = S_SQR;
        end
      end
      S_MUL: begin
        if (mm_rsp.done) begin
          acc_nxt = mm_rsp.result;
          e_nxt   = e_shift;
          if (e_shift != '0) begin
            mm_req.start = 1'b1;
            mm_req.a     = sq_r;
            state_nxt    = S_SQR;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SQR: begin
        if (mm_rsp.done) begin
          sq_nxt    = mm_rsp.result;
          state_nxt = S_STEP;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_result_nxt = acc_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      exp_r       <= '0;
      mod_r       <= word_t'(2);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we && cfg_index == CFG_EXPONENT) begin
        exp_r <= cfg_wdata;
      end
      if (cfg_we && cfg_index == CFG_MODULUS) begin
        mod_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    e_r          <= e_nxt;
    acc_r        <= acc_nxt;
    sq_r         <= sq_nxt;
    out_result_r <= out_result_nxt;
  end

  assign in_chan.ready         = (state_r == S_IDLE);
  assign out_chan.valid        = out_valid_r;
  assign out_chan.result_value = out_result_r;

endmodule

@@ rtl/mexp_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Modular exponentiation checker
// Port-level checks on reset, item acceptance and result hold.
// ----------------------------------------------------------------------------
module mexp_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input mexp_pkg::word_t out_result
);

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  a_ready_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("not ready after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result))
    else $error("stalled result changed");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_result (out_chan.result_value)
);
